[rtl/crt_pkg.sv]
// Shared constants, codes and control types of the page reference count table.
package crt_pkg;

  localparam int ENTRIES       = 512;
  localparam int IDX_W         = $clog2(ENTRIES);
  localparam int FRAME_BITS    = 40;
  localparam int COUNT_BITS    = 8;
  localparam int CMD_BITS      = 2;
  localparam int OUTCOME_BITS  = 3;
  localparam int TOTAL_BITS    = 17;
  localparam int DROP_BITS     = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] INSTALL_COUNT = COUNT_BITS'(2);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX     = {TOTAL_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      LAST_IDX      = IDX_W'(ENTRIES - 1);

  localparam logic [CMD_BITS-1:0] CMD_TRACK   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RESOLVE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd3;

  localparam logic [OUTCOME_BITS-1:0] OC_SHARED       = 3'd0;
  localparam logic [OUTCOME_BITS-1:0] OC_TABLE_FULL   = 3'd1;
  localparam logic [OUTCOME_BITS-1:0] OC_NOT_TRACKED  = 3'd2;
  localparam logic [OUTCOME_BITS-1:0] OC_UPGRADE      = 3'd3;
  localparam logic [OUTCOME_BITS-1:0] OC_PRIVATE_COPY = 3'd4;
  localparam logic [OUTCOME_BITS-1:0] OC_UNMAP        = 3'd5;
  localparam logic [OUTCOME_BITS-1:0] OC_FORGET       = 3'd6;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [COUNT_BITS-1:0] count;
  } crt_entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic apply;
  } crt_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } crt_sts_t;

endpackage

[rtl/crt_ifs.sv]
// Valid/ready channel interfaces for the command items and the result items.
interface crt_in_if;
  logic                                valid;
  logic                                ready;
  logic [crt_pkg::CMD_BITS-1:0]        command;
  logic [crt_pkg::FRAME_BITS-1:0]      phys_frame;

  modport source (output valid, output command, output phys_frame, input ready);
  modport sink   (input valid, input command, input phys_frame, output ready);
endinterface

interface crt_out_if;
  logic                                valid;
  logic                                ready;
  logic [crt_pkg::OUTCOME_BITS-1:0]    outcome;
  logic [crt_pkg::COUNT_BITS-1:0]      count_after;
  logic [crt_pkg::TOTAL_BITS-1:0]      shared_total;
  logic [crt_pkg::DROP_BITS-1:0]       drop_count;

  modport source (output valid, output outcome, output count_after, output shared_total,
                  output drop_count, input ready);
  modport sink   (input valid, input outcome, input count_after, input shared_total,
                  input drop_count, output ready);
endinterface

[rtl/crt_ctrl.sv]
// Controller state machine: clearing pass, table scan and result update.
module crt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crt_pkg::crt_sts_t sts,
  output crt_pkg::crt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_APPLY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd.clear = (state_r == S_CLEAR);
    cmd.load  = in_ready_r && in_valid;
    cmd.scan  = (state_r == S_SCAN);
    cmd.apply = (state_r == S_APPLY) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.addr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.load) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.addr_last) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

[rtl/crt_datapath.sv]
// Datapath: table memory, scan pipeline, match and free search, totals and result register.
module crt_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crt_pkg::crt_cmd_t                   cmd,
  output crt_pkg::crt_sts_t                   sts,
  input  logic [crt_pkg::CMD_BITS-1:0]        in_command,
  input  logic [crt_pkg::FRAME_BITS-1:0]      in_frame,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [crt_pkg::OUTCOME_BITS-1:0]    out_outcome,
  output logic [crt_pkg::COUNT_BITS-1:0]      out_count_after,
  output logic [crt_pkg::TOTAL_BITS-1:0]      out_shared_total,
  output logic [crt_pkg::DROP_BITS-1:0]       out_drop_count
);

  crt_pkg::crt_entry_t                   mem [crt_pkg::ENTRIES];

  logic [crt_pkg::IDX_W-1:0]             scan_addr_r;
  logic                                  rd_vld_r;
  logic [crt_pkg::IDX_W-1:0]             rd_idx_r;
  crt_pkg::crt_entry_t                   rd_data_r;

  logic [crt_pkg::CMD_BITS-1:0]          req_cmd_r;
  logic [crt_pkg::FRAME_BITS-1:0]        req_frame_r;
  logic                                  hit_r;
  logic [crt_pkg::IDX_W-1:0]             hit_idx_r;
  logic [crt_pkg::COUNT_BITS-1:0]        hit_cnt_r;
  logic                                  free_r;
  logic [crt_pkg::IDX_W-1:0]             free_idx_r;
  logic [crt_pkg::TOTAL_BITS-1:0]        total_r;
  logic [crt_pkg::TOTAL_BITS-1:0]        total_nxt;
  logic [crt_pkg::TOTAL_BITS:0]          total_sum;

  logic [crt_pkg::DROP_BITS-1:0]         refused_r;
  logic [crt_pkg::DROP_BITS-1:0]         refused_nxt;
  logic                                  out_valid_r;
  logic [crt_pkg::OUTCOME_BITS-1:0]      outcome_r;
  logic [crt_pkg::OUTCOME_BITS-1:0]      outcome_nxt;
  logic [crt_pkg::COUNT_BITS-1:0]        count_r;
  logic [crt_pkg::COUNT_BITS-1:0]        count_nxt;
  logic [crt_pkg::TOTAL_BITS-1:0]        shared_r;

  logic                                  rd_live;
  logic                                  rd_match;
  logic                                  upd_wr;
  logic [crt_pkg::IDX_W-1:0]             upd_addr;
  crt_pkg::crt_entry_t                   upd_data;
  logic                                  wr_en;
  logic [crt_pkg::IDX_W-1:0]             wr_addr;
  crt_pkg::crt_entry_t                   wr_data;

  assign sts.addr_last = (scan_addr_r == crt_pkg::LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign rd_live  = (rd_data_r.count != '0);
  assign rd_match = rd_live && (rd_data_r.frame == req_frame_r);

  assign total_sum = {1'b0, total_r} + crt_pkg::TOTAL_BITS'(rd_data_r.count);
  assign total_nxt = total_sum[crt_pkg::TOTAL_BITS] ? crt_pkg::TOTAL_MAX
                                                    : total_sum[crt_pkg::TOTAL_BITS-1:0];

  always_comb begin
    outcome_nxt = crt_pkg::OC_SHARED;
    count_nxt   = '0;
    refused_nxt = refused_r;
    upd_wr      = 1'b0;
    upd_addr    = hit_idx_r;
    upd_data    = '{frame: req_frame_r, count: '0};
    case (req_cmd_r)
      crt_pkg::CMD_TRACK: begin
        if (hit_r) begin
          if (hit_cnt_r == crt_pkg::COUNT_MAX) begin
            outcome_nxt = crt_pkg::OC_TABLE_FULL;
            refused_nxt = refused_r + 1'b1;
            count_nxt   = hit_cnt_r;
          end else begin
            upd_wr         = 1'b1;
            upd_data.count = hit_cnt_r + 1'b1;
            count_nxt      = hit_cnt_r + 1'b1;
          end
        end else if (free_r) begin
          upd_wr         = 1'b1;
          upd_addr       = free_idx_r;
          upd_data.count = crt_pkg::INSTALL_COUNT;
          count_nxt      = crt_pkg::INSTALL_COUNT;
        end else begin
          outcome_nxt = crt_pkg::OC_TABLE_FULL;
          refused_nxt = refused_r + 1'b1;
        end
      end
      crt_pkg::CMD_RESOLVE, crt_pkg::CMD_RELEASE: begin
        if (!hit_r) begin
          outcome_nxt = crt_pkg::OC_NOT_TRACKED;
        end else if (hit_cnt_r <= crt_pkg::COUNT_BITS'(1)) begin
          upd_wr      = 1'b1;
          outcome_nxt = (req_cmd_r == crt_pkg::CMD_RESOLVE) ? crt_pkg::OC_UPGRADE
                                                            : crt_pkg::OC_FORGET;
        end else begin
          upd_wr         = 1'b1;
          upd_data.count = hit_cnt_r - 1'b1;
          count_nxt      = hit_cnt_r - 1'b1;
          outcome_nxt    = (req_cmd_r == crt_pkg::CMD_RESOLVE) ? crt_pkg::OC_PRIVATE_COPY
                                                               : crt_pkg::OC_UNMAP;
        end
      end
      default: begin
        outcome_nxt = crt_pkg::OC_SHARED;
      end
    endcase
  end

  assign wr_en   = cmd.clear || (cmd.apply && upd_wr);
  assign wr_addr = cmd.clear ? scan_addr_r : upd_addr;
  assign wr_data = cmd.clear ? crt_pkg::crt_entry_t'('0) : upd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      refused_r   <= '0;
    end else begin
      if (cmd.clear || cmd.scan) begin
        scan_addr_r <= sts.addr_last ? '0 : scan_addr_r + 1'b1;
      end
      rd_vld_r <= cmd.scan;
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
        refused_r   <= refused_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
    if (cmd.load) begin
      req_cmd_r   <= in_command;
      req_frame_r <= in_frame;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      total_r     <= '0;
    end else if (rd_vld_r) begin
      if (rd_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_cnt_r <= rd_data_r.count;
      end
      if (!rd_live && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (rd_data_r.count > crt_pkg::COUNT_BITS'(1)) begin
        total_r <= total_nxt;
      end
    end
    if (cmd.apply) begin
      outcome_r <= outcome_nxt;
      count_r   <= count_nxt;
      shared_r  <= (req_cmd_r == crt_pkg::CMD_QUERY) ? total_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_count_after  = count_r;
  assign out_shared_total = shared_r;
  assign out_drop_count   = refused_r;

endmodule

[rtl/cow_page_refcount_table.sv]
// Top level of the copy-on-write page reference count table.
// Commands arrive on in_ch (command, phys_frame) and each one gives exactly one
// result item on out_ch (outcome, count_after, shared_total, drop_count).
// Every command reads the whole 512-entry table through the single read port of
// the table memory, one entry per cycle, to find the lowest matching live entry,
// the lowest free entry and the sum of the counts above one.
// Each item runs through the scan state, which reads every entry, a wait state for
// the last read data and an update state that holds until the output register is
// free. One item is in work at a time; the next is taken after the last one's update.
// A result waits in the output register until taken; the block accepts the next
// item meanwhile, and if that item finishes first it holds in its update cycle
// until the output register is free.
// After reset the table is cleared one entry per cycle, and in_ch.ready stays low
// until the clearing pass ends; the refused track counter returns to zero.
module cow_page_refcount_table (
  input logic       clk,
  input logic       rst_n,
  crt_in_if.sink    in_ch,
  crt_out_if.source out_ch
);

  crt_pkg::crt_cmd_t cmd;
  crt_pkg::crt_sts_t sts;
  logic              in_ready;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_frame         (in_ch.phys_frame),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_outcome      (out_ch.outcome),
    .out_count_after  (out_ch.count_after),
    .out_shared_total (out_ch.shared_total),
    .out_drop_count   (out_ch.drop_count)
  );

  assign in_ch.ready = in_ready;

endmodule

[rtl/crt_checker.sv]
// Port-level checks of the page reference count table and their binding.
module crt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [crt_pkg::OUTCOME_BITS-1:0]    outcome,
  input logic [crt_pkg::COUNT_BITS-1:0]      count_after,
  input logic [crt_pkg::TOTAL_BITS-1:0]      shared_total,
  input logic [crt_pkg::DROP_BITS-1:0]       drop_count
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken right after reset, during the table clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(count_after)
      && $stable(shared_total) && $stable(drop_count))
    else $error("stalled result item changed");

  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome == crt_pkg::OC_NOT_TRACKED || outcome == crt_pkg::OC_UPGRADE ||
                  outcome == crt_pkg::OC_FORGET)
      |-> count_after == '0 && shared_total == '0)
    else $error("freed or untracked result carries a count");

endmodule

bind cow_page_refcount_table crt_checker u_crt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .outcome      (out_ch.outcome),
  .count_after  (out_ch.count_after),
  .shared_total (out_ch.shared_total),
  .drop_count   (out_ch.drop_count)
);
